FILE: hdl/tgcm_pkg.sv
// ----------------------------------------------------------------------------
// tgcm_pkg
// Shared types and constants for the tile grid collision map.
// ----------------------------------------------------------------------------
package tgcm_pkg;

  // Signed coordinate width: holds pixel edges up to 64 tiles of 64 pixels.
  localparam int COORD_W = 14;

  // Reciprocal shift of the divide-by-tile unit, exact for |n| < 2**13, tile <= 64.
  localparam int DIV_SH = 20;

  localparam int ROW_BITS_W = 16;

  localparam logic [2:0] CMD_LOAD       = 3'd0;
  localparam logic [2:0] CMD_CLEAR      = 3'd1;
  localparam logic [2:0] CMD_QUERY_PT   = 3'd2;
  localparam logic [2:0] CMD_QUERY_RECT = 3'd3;
  localparam logic [2:0] CMD_MARK_PT    = 3'd4;
  localparam logic [2:0] CMD_MARK_RECT  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_WALK,
    ST_FINISH
  } state_e;

  typedef logic signed [COORD_W-1:0] coord_t;

endpackage

FILE: hdl/tile_grid_collision_map.sv
// ----------------------------------------------------------------------------
// tile_grid_collision_map
// Static and dynamic tile occupancy maps with point and rectangle queries.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carries one command request with its
// coordinates, sizes and row bits. Output channel: out_valid_o / out_stall_i
// carries one hit flag per request, 0 for every non-query command.
// One request is worked on at a time; in_stall_o is high while it runs.
// Each request passes through these states before its result is registered:
//   load, clear, unused codes : set-up, finish
//   point query / mark        : divide, set-up, walk, finish; the walk is
//                               skipped when the point lies off the map
//   rectangle query / mark    : divide, set-up, walk of each map row
//                               covered, finish; no row is walked for an
//                               empty rectangle, a query that leaves the map
//                               or a mark clipped away.
// The divide step uses the shared reciprocal multiplier, which converts four
// pixel edges to tiles one per cycle, and the walk uses the single map row
// port, which it reads or updates one row per cycle.
// The result sits in an output register, so a new request is taken while
// the receiver stalls; a finished request then waits until the register
// frees up. Reset clears both maps and all control state at once.
// ----------------------------------------------------------------------------
module tile_grid_collision_map #(
  parameter int MAP_COLS    = 16,
  parameter int MAP_ROWS    = 12,
  parameter int TILE_PIXELS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          command_i,
  input  logic signed [10:0]  pos_x_i,
  input  logic signed [10:0]  pos_y_i,
  input  logic [8:0]          rect_width_i,
  input  logic [8:0]          rect_height_i,
  input  logic [15:0]         row_bits_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                hit_o
);

  localparam int CW = tgcm_pkg::COORD_W;
  localparam int MW = CW - 1;
  localparam int RW = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int RECIP_W = tgcm_pkg::DIV_SH + 1;
  localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((2**tgcm_pkg::DIV_SH + TILE_PIXELS - 1) / TILE_PIXELS);

  localparam tgcm_pkg::coord_t COLS_S    = CW'(MAP_COLS);
  localparam tgcm_pkg::coord_t ROWS_S    = CW'(MAP_ROWS);
  localparam tgcm_pkg::coord_t COL_MAX_S = CW'(MAP_COLS - 1);
  localparam tgcm_pkg::coord_t ROW_MAX_S = CW'(MAP_ROWS - 1);
  localparam tgcm_pkg::coord_t COL_PIX_S = CW'(MAP_COLS * TILE_PIXELS);
  localparam tgcm_pkg::coord_t ROW_PIX_S = CW'(MAP_ROWS * TILE_PIXELS);
  localparam tgcm_pkg::coord_t ZERO_S    = '0;

  tgcm_pkg::state_e state_q, state_d;

  logic [2:0]                     cmd_q;
  tgcm_pkg::coord_t               x_q, y_q, r_q, b_q;
  logic                           empty_q;
  logic [tgcm_pkg::ROW_BITS_W-1:0] row_bits_q;

  tgcm_pkg::coord_t tile_q [4];
  logic [1:0]       div_cnt_q, div_cnt_d;

  logic [RW-1:0]       row_q, row_d, last_q, last_d;
  logic [MAP_COLS-1:0] mask_q, mask_d;
  logic                hit_q, hit_d;
  logic                out_valid_q, out_valid_d, out_hit_q, out_hit_d;

  logic [MAP_COLS-1:0] stat_q [MAP_ROWS];
  logic [MAP_COLS-1:0] dyn_q  [MAP_ROWS];

  logic accept, ld_en, clr_en, mark_en, finish_fire;
  logic is_query;

  // ------------------------------------------------------------------------
  // Request capture
  // ------------------------------------------------------------------------
  tgcm_pkg::coord_t x_ext, y_ext, w_ext, h_ext, r_in, b_in;
  logic             pt_cmd_in;

  always_comb begin
    x_ext     = {{(CW-11){pos_x_i[10]}}, pos_x_i};
    y_ext     = {{(CW-11){pos_y_i[10]}}, pos_y_i};
    w_ext     = {{(CW-9){1'b0}}, rect_width_i};
    h_ext     = {{(CW-9){1'b0}}, rect_height_i};
    pt_cmd_in = (command_i == tgcm_pkg::CMD_QUERY_PT) ||
                (command_i == tgcm_pkg::CMD_MARK_PT);
    // Point commands reuse the edge path with the far edge on the point.
    r_in      = pt_cmd_in ? x_ext : x_ext + w_ext - CW'(1);
    b_in      = pt_cmd_in ? y_ext : y_ext + h_ext - CW'(1);
  end

  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= command_i;
      x_q        <= x_ext;
      y_q        <= y_ext;
      r_q        <= r_in;
      b_q        <= b_in;
      empty_q    <= (rect_width_i == '0) || (rect_height_i == '0);
      row_bits_q <= row_bits_i;
    end
  end

  // ------------------------------------------------------------------------
  // Shared divide-by-tile unit: reciprocal multiply on the magnitude
  // ------------------------------------------------------------------------
  tgcm_pkg::coord_t       div_op, div_res;
  logic                   div_neg;
  logic [MW-1:0]          div_mag, div_quo;
  logic [MW+RECIP_W-1:0]  div_prod;

  always_comb begin
    case (div_cnt_q)
      2'd0:    div_op = x_q;
      2'd1:    div_op = r_q;
      2'd2:    div_op = y_q;
      default: div_op = b_q;
    endcase
    div_neg  = div_op[CW-1];
    div_mag  = div_neg ? MW'(-div_op) : MW'(div_op);
    div_prod = {{RECIP_W{1'b0}}, div_mag} * {{MW{1'b0}}, RECIP};
    div_quo  = div_prod[tgcm_pkg::DIV_SH +: MW];
    // Truncate toward zero: negate the quotient of the magnitude.
    div_res  = div_neg ? -{1'b0, div_quo} : {1'b0, div_quo};
  end

  always_ff @(posedge clk_i) begin
    if (state_q == tgcm_pkg::ST_DIV) begin
      tile_q[div_cnt_q] <= div_res;
    end
  end

  // ------------------------------------------------------------------------
  // Set-up: bounds, clipping and column mask
  // ------------------------------------------------------------------------
  tgcm_pkg::coord_t lt_c, rt_c, tt_c, bt_c;
  logic             pt_in_map, rect_out, clip_empty;
  logic [MAP_COLS-1:0] span;

  always_comb begin
    lt_c = tile_q[0][CW-1] ? ZERO_S : tile_q[0];
    rt_c = (tile_q[1] > COL_MAX_S) ? COL_MAX_S : tile_q[1];
    tt_c = tile_q[2][CW-1] ? ZERO_S : tile_q[2];
    bt_c = (tile_q[3] > ROW_MAX_S) ? ROW_MAX_S : tile_q[3];
    pt_in_map = !tile_q[0][CW-1] && (tile_q[0] < COLS_S) &&
                !tile_q[2][CW-1] && (tile_q[2] < ROWS_S);
    rect_out  = x_q[CW-1] || y_q[CW-1] || (r_q >= COL_PIX_S) || (b_q >= ROW_PIX_S);
    clip_empty = (lt_c > rt_c) || (tt_c > bt_c);
    for (int c = 0; c < MAP_COLS; c++) begin
      span[c] = (lt_c <= CW'(c)) && (rt_c >= CW'(c));
    end
  end

  assign is_query = (cmd_q == tgcm_pkg::CMD_QUERY_PT) ||
                    (cmd_q == tgcm_pkg::CMD_QUERY_RECT);

  // ------------------------------------------------------------------------
  // Sequencer
  // ------------------------------------------------------------------------
  logic [MAP_COLS-1:0] row_data;

  assign row_data = stat_q[row_q] | dyn_q[row_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tgcm_pkg::ST_IDLE;
      div_cnt_q   <= '0;
      row_q       <= '0;
      last_q      <= '0;
      mask_q      <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_hit_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_cnt_q   <= div_cnt_d;
      row_q       <= row_d;
      last_q      <= last_d;
      mask_q      <= mask_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      out_hit_q   <= out_hit_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    div_cnt_d   = div_cnt_q;
    row_d       = row_q;
    last_d      = last_q;
    mask_d      = mask_q;
    hit_d       = hit_q;
    ld_en       = 1'b0;
    clr_en      = 1'b0;
    mark_en     = 1'b0;
    finish_fire = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_hit_d   = out_hit_q;

    unique case (state_q)
      tgcm_pkg::ST_IDLE: begin
        if (accept) begin
          hit_d     = 1'b0;
          div_cnt_d = '0;
          if ((command_i == tgcm_pkg::CMD_QUERY_PT) ||
              (command_i == tgcm_pkg::CMD_QUERY_RECT) ||
              (command_i == tgcm_pkg::CMD_MARK_PT) ||
              (command_i == tgcm_pkg::CMD_MARK_RECT)) begin
            state_d = tgcm_pkg::ST_DIV;
          end else begin
            state_d = tgcm_pkg::ST_SETUP;
          end
        end
      end

      tgcm_pkg::ST_DIV: begin
        div_cnt_d = div_cnt_q + 2'd1;
        if (div_cnt_q == 2'd3) begin
          state_d = tgcm_pkg::ST_SETUP;
        end
      end

      tgcm_pkg::ST_SETUP: begin
        state_d = tgcm_pkg::ST_FINISH;
        row_d   = tt_c[RW-1:0];
        last_d  = bt_c[RW-1:0];
        mask_d  = span;
        unique case (cmd_q) inside
          tgcm_pkg::CMD_LOAD: begin
            ld_en = !y_q[CW-1] && (y_q < ROWS_S);
          end
          tgcm_pkg::CMD_CLEAR: begin
            clr_en = 1'b1;
          end
          tgcm_pkg::CMD_QUERY_PT, tgcm_pkg::CMD_MARK_PT: begin
            if (pt_in_map) begin
              state_d = tgcm_pkg::ST_WALK;
            end else begin
              hit_d = is_query;
            end
          end
          tgcm_pkg::CMD_QUERY_RECT: begin
            if (!empty_q) begin
              if (rect_out) begin
                hit_d = 1'b1;
              end else begin
                state_d = tgcm_pkg::ST_WALK;
              end
            end
          end
          tgcm_pkg::CMD_MARK_RECT: begin
            if (!empty_q && !clip_empty) begin
              state_d = tgcm_pkg::ST_WALK;
            end
          end
          default: begin
          end
        endcase
      end

      tgcm_pkg::ST_WALK: begin
        if (is_query) begin
          hit_d = hit_q | (|(row_data & mask_q));
        end else begin
          mark_en = 1'b1;
        end
        if (row_q == last_q) begin
          state_d = tgcm_pkg::ST_FINISH;
        end else begin
          row_d = row_q + RW'(1);
        end
      end

      tgcm_pkg::ST_FINISH: begin
        // Hold until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          finish_fire = 1'b1;
          out_valid_d = 1'b1;
          out_hit_d   = hit_q;
          state_d     = tgcm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tgcm_pkg::ST_IDLE;
      end
    endcase
  end

  // ------------------------------------------------------------------------
  // Occupancy maps
  // ------------------------------------------------------------------------
  logic [63:0]         row_wide;
  logic [MAP_COLS-1:0] load_row;
  logic [RW-1:0]       load_idx;

  assign row_wide = {{(64-tgcm_pkg::ROW_BITS_W){1'b0}}, row_bits_q};
  assign load_row = row_wide[MAP_COLS-1:0];
  assign load_idx = y_q[RW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAP_ROWS; i++) begin
        stat_q[i] <= '0;
        dyn_q[i]  <= '0;
      end
    end else if (clr_en) begin
      for (int i = 0; i < MAP_ROWS; i++) begin
        stat_q[i] <= '0;
        dyn_q[i]  <= '0;
      end
    end else begin
      if (ld_en) begin
        stat_q[load_idx] <= load_row;
      end
      if (mark_en) begin
        dyn_q[row_q] <= dyn_q[row_q] | mask_q;
      end
    end
  end

  assign in_stall_o  = (state_q != tgcm_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;

  // ------------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("request accepted but block not busy");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tgcm_pkg::ST_WALK) |-> (row_q <= last_q))
    else $error("row walk passed its last row");

  a_non_query_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish_fire && !is_query) |=> (out_valid_o && !hit_o))
    else $error("non-query request produced a hit");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_en |=> ((stat_q[0] == '0) && (dyn_q[0] == '0)))
    else $error("clear left map bits set");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tgcm_pkg::ST_FINISH && out_valid_q && out_stall_i) |=>
      (state_q == tgcm_pkg::ST_FINISH && $stable(out_hit_q)))
    else $error("result overwritten while receiver stalled");

endmodule
